// ===== design/btme_pkg.sv =====
// Shared types and constants for the branch trace message encoder.
// Used by the front end, the descriptor queue and the byte serializer.
`default_nettype none
package btme_pkg;

    localparam int DEF_ADDR_BITS  = 32;
    localparam int DEF_HIST_BITS  = 31;
    localparam int DEF_ADDR_SKIP  = 1;
    localparam int DEF_RCODE_BITS = 4;

    localparam int IN_DATA_W  = 40;   // pc, is_32bit, is_branch, not_taken, is_indirect + pad
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int QDEPTH     = 2;
    localparam int NFLD       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EN  = 1'd1;

    localparam logic [5:0] TC_NONE     = 6'd0;
    localparam logic [5:0] TC_DIRECT   = 6'd3;
    localparam logic [5:0] TC_INDIRECT = 6'd4;
    localparam logic [5:0] TC_REPEAT   = 6'd8;
    localparam logic [5:0] TC_SYNC     = 6'd9;
    localparam logic [5:0] TC_FULL     = 6'd27;
    localparam logic [5:0] TC_INDHIST  = 6'd28;
    localparam logic [5:0] TC_CORR     = 6'd33;

    localparam logic [1:0] MODE_BRANCH  = 2'd0;
    localparam logic [1:0] MODE_HIST    = 2'd1;
    localparam logic [1:0] MODE_HIST_RP = 2'd2;

    localparam logic [7:0] RCODE_ONE   = 8'h04;   // 0x1 << 2
    localparam logic [7:0] RCODE_MULTI = 8'h08;   // 0x2 << 2

    // One variable-length field: low nprev bits go into the previous byte,
    // force makes at least one byte.
    typedef struct packed {
        logic        vld;
        logic        frc;
        logic [2:0]  nprev;
        logic [31:0] val;
    } fld_t;

    typedef struct packed {
        logic            vld;
        logic [7:0]      hdr0;
        logic            hdr1_vld;
        logic [7:0]      hdr1;
        fld_t [NFLD-1:0] fld;
    } msg_t;

    typedef struct packed {
        msg_t [1:0] msg;
    } desc_t;

    function automatic fld_t mk_fld(input logic [31:0] v, input logic [2:0] np,
                                    input logic frc);
        fld_t f;
        f.vld   = 1'b1;
        f.frc   = frc;
        f.nprev = np;
        f.val   = v;
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== design/btme_front.sv =====
// Front end: accepts retired instructions, keeps trace state, builds message descriptors.
// Depends on btme_pkg.
`default_nettype none
module btme_front import btme_pkg::*; #(
    parameter int ADDR_BITS  = DEF_ADDR_BITS,
    parameter int HIST_BITS  = DEF_HIST_BITS,
    parameter int ADDR_SKIP  = DEF_ADDR_SKIP,
    parameter int RCODE_BITS = DEF_RCODE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_user,
    output logic                  push,
    output desc_t                 push_desc,
    input  logic                  q_full
);

    localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [2:0] RC_NPREV = 3'(6 - RCODE_BITS);

    logic [1:0]  mode_reg, rep_en_reg;
    logic [5:0]  pend_reg, pend_next;
    logic [31:0] ic_reg, ic_next, hist_reg, hist_next, la_reg, la_next;
    logic [31:0] rc_reg, rc_next, pcnt_reg, pcnt_next, ph_reg, ph_next;
    logic [31:0] pw_reg, pw_next;
    logic [4:0]  plen_reg, plen_next;
    logic [1:0]  psh_reg, psh_next;
    logic        accept;

    function automatic logic [4:0] pat_match(input logic [31:0] p, input logic [31:0] h);
        logic [4:0] r;
        r = 5'd0;
        if (p[2:0] == p[30:28] && (p & 32'h0FFF_FFF8) == ((h >> 3) & 32'h0FFF_FFF8))
            r = 5'd28;
        else if (p[0] == p[30] && (p & 32'h3FFF_FFFE) == ((h >> 1) & 32'h3FFF_FFFE))
            r = 5'd30;
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && push_desc.msg[0].vld;

    always_comb begin
        logic        flush, is4, br, nt, ind, rep;
        logic [31:0] addr, m_mask;
        logic [1:0]  mode;
        logic [5:0]  code;
        logic [4:0]  m;
        logic [2:0]  s2;
        msg_t        rmsg, mmsg;

        flush = in_user;
        addr  = in_data[31:0] & ADDR_MASK;
        is4   = in_data[32];
        br    = in_data[33];
        nt    = in_data[34];
        ind   = in_data[35];
        mode  = (mode_reg == 2'd3) ? MODE_HIST_RP : mode_reg;

        pend_next = pend_reg;  ic_next = ic_reg;   hist_next = hist_reg;
        la_next   = la_reg;    rc_next = rc_reg;   pcnt_next = pcnt_reg;
        ph_next   = ph_reg;    pw_next = pw_reg;   plen_next = plen_reg;
        psh_next  = psh_reg;
        rmsg = '0;  mmsg = '0;  rep = 1'b0;  m = 5'd0;  s2 = 3'd0;  m_mask = '0;
        code = TC_NONE;

        if (flush && (ic_next != 0 || plen_next != 0)) begin
            if (pend_next == TC_NONE) pend_next = TC_CORR;
            if (rc_next != 0) ph_next = '0;
        end

        if (pend_next != TC_NONE) begin
            code = pend_next;
            if (mode == MODE_HIST_RP) begin
                if (rep_en_reg[1] && code == TC_FULL) begin
                    if (plen_next == 0) begin
                        plen_next = 5'd31; psh_next = 2'd0; pw_next = hist_next;
                        rc_next = '0; rep = 1'b1; hist_next = 32'd1;
                    end else if ((hist_next >> psh_next) == pw_next) begin
                        m_mask    = (32'd1 << psh_next) - 32'd1;
                        hist_next = (32'd1 << psh_next) | (hist_next & m_mask);
                        rep = 1'b1;
                    end else if (rc_next == 32'd1) begin
                        m = pat_match(pw_next, hist_next);
                        if (m != 0) begin
                            plen_next = m;
                            psh_next  = 2'(5'd31 - m);
                            pw_next   = pw_next >> psh_next;
                            s2        = {psh_next, 1'b0};
                            m_mask    = (32'd1 << s2) - 32'd1;
                            hist_next = (32'd1 << s2) | (hist_next & m_mask);
                            rep = 1'b1;
                        end
                    end
                end else if (rep_en_reg[0] && code != TC_FULL && ph_next == hist_next &&
                             la_next == addr && pcnt_next == ic_next) begin
                    rep = 1'b1; ic_next = '0; hist_next = 32'd1;
                end

                if (rep) begin
                    rc_next = rc_next + 32'd1;
                    code = TC_NONE;
                end else if (rc_next != 0 && plen_next != 0) begin
                    rmsg.vld      = 1'b1;
                    rmsg.hdr0     = {TC_FULL, 2'b00};
                    rmsg.hdr1_vld = 1'b1;
                    rmsg.hdr1     = (rc_next > 32'd1) ? RCODE_MULTI : RCODE_ONE;
                    rmsg.fld[0]   = mk_fld(pw_next, RC_NPREV, 1'b0);
                    if (rc_next > 32'd1) rmsg.fld[1] = mk_fld(rc_next, 3'd0, 1'b0);
                    if (code == TC_FULL) begin
                        plen_next = 5'd31; psh_next = 2'd0; pw_next = hist_next;
                        rc_next = 32'd1; code = TC_NONE; hist_next = 32'd1;
                    end else begin
                        rc_next = '0; plen_next = '0;
                    end
                end else if (rc_next != 0) begin
                    rmsg.vld    = 1'b1;
                    rmsg.hdr0   = {TC_REPEAT, 2'b00};
                    rmsg.fld[0] = mk_fld(rc_next, 3'd0, 1'b0);
                    rc_next = '0;
                end
            end

            if (code == TC_INDHIST && hist_next == 32'd1) code = TC_INDIRECT;
            if (rc_next == 0) ph_next = '0;
            mmsg.hdr0 = {code, 2'b00};
            case (code)
                TC_SYNC: begin
                    mmsg.vld = 1'b1; mmsg.hdr1_vld = 1'b1; mmsg.hdr1 = RCODE_ONE;
                    mmsg.fld[0] = mk_fld(ic_next, 3'd2, 1'b0);
                    mmsg.fld[1] = mk_fld(addr >> ADDR_SKIP, 3'd0, 1'b0);
                    ic_next = '0; la_next = addr;
                end
                TC_INDIRECT, TC_INDHIST: begin
                    ph_next = hist_next; pcnt_next = ic_next;
                    mmsg.vld = 1'b1; mmsg.hdr1_vld = 1'b1; mmsg.hdr1 = 8'h00;
                    mmsg.fld[0] = mk_fld(ic_next, 3'd4, 1'b0);
                    mmsg.fld[1] = mk_fld((la_next ^ addr) >> ADDR_SKIP, 3'd0, 1'b1);
                    if (code == TC_INDHIST) mmsg.fld[2] = mk_fld(hist_next, 3'd0, 1'b0);
                    ic_next = '0; la_next = addr;
                end
                TC_DIRECT: begin
                    mmsg.vld = 1'b1;
                    mmsg.fld[0] = mk_fld(ic_next, 3'd0, 1'b1);
                    ic_next = '0;
                end
                TC_FULL: begin
                    ph_next = hist_next; pcnt_next = ic_next;
                    mmsg.vld = 1'b1; mmsg.hdr1_vld = 1'b1; mmsg.hdr1 = RCODE_ONE;
                    mmsg.fld[0] = mk_fld(hist_next, RC_NPREV, 1'b0);
                end
                TC_CORR: begin
                    mmsg.vld = 1'b1; mmsg.hdr1_vld = 1'b1;
                    mmsg.hdr1 = (hist_next > 32'd1) ? 8'h40 : 8'h00;
                    mmsg.fld[0] = mk_fld(ic_next, 3'd0, 1'b1);
                    if (hist_next > 32'd1) mmsg.fld[1] = mk_fld(hist_next, 3'd0, 1'b0);
                    ic_next = '0;
                end
                default: ;
            endcase
            pend_next = TC_NONE;
            if (plen_next == 0) hist_next = 32'd1;
        end

        ic_next = ic_next + ((!flush && is4) ? 32'd2 : 32'd1);
        if (!flush) begin
            if (br) begin
                if (mode != MODE_BRANCH) begin
                    hist_next = {hist_next[30:0], !nt};
                    if (hist_next[HIST_BITS]) pend_next = TC_FULL;
                end else if (!nt) begin
                    pend_next = TC_DIRECT;
                end
            end else if (ind) begin
                pend_next = (mode != MODE_BRANCH) ? TC_INDHIST : TC_INDIRECT;
            end
        end

        push_desc = '0;
        if (rmsg.vld) begin
            push_desc.msg[0] = rmsg;
            push_desc.msg[1] = mmsg;
        end else begin
            push_desc.msg[0] = mmsg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HIST_RP;  rep_en_reg <= 2'd3;
            pend_reg <= TC_SYNC;  ic_reg <= '0;  hist_reg <= 32'd1;  la_reg <= '0;
            rc_reg <= '0;  pcnt_reg <= '0;  ph_reg <= '0;  pw_reg <= '0;
            plen_reg <= '0;  psh_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TRACE_MODE: mode_reg   <= cfg_wr_data;
                    CFG_REPEAT_EN:  rep_en_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept) begin
                pend_reg <= pend_next;  ic_reg <= ic_next;  hist_reg <= hist_next;
                la_reg <= la_next;  rc_reg <= rc_next;  pcnt_reg <= pcnt_next;
                ph_reg <= ph_next;  pw_reg <= pw_next;  plen_reg <= plen_next;
                psh_reg <= psh_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/btme_queue.sv =====
// Short descriptor queue between the front end and the byte serializer.
// Depends on btme_pkg.
`default_nettype none
module btme_queue import btme_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_vld,
    output desc_t head_desc
);

    localparam int PW = $clog2(QDEPTH);

    desc_t          mem_reg [QDEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(QDEPTH));
    assign head_vld  = (cnt_reg != '0);
    assign head_desc = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/btme_back.sv =====
// Back end: walks a message descriptor and emits message bytes, one per beat.
// Depends on btme_pkg.
`default_nettype none
module btme_back import btme_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_vld,
    input  desc_t                 q_desc,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_DATA_W-1:0] m_data,
    output logic                  m_eom,
    output logic                  m_last
);

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_FSTART, PH_FCHUNK, PH_MEND, PH_FLUSH
    } phase_t;

    phase_t      ph_reg, ph_next;
    logic        midx_reg, midx_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [31:0] val_reg, val_next;
    logic        frc_reg, frc_next;
    logic [7:0]  hold_reg;
    logic        hold_vld_reg;
    logic        out_free, can_emit, emit_req, or_req, flush_req;
    logic [7:0]  emit_byte, or_bits;
    msg_t        cur_msg;
    fld_t        cur_fld;

    assign cur_msg  = q_desc.msg[midx_reg];
    assign cur_fld  = cur_msg.fld[fidx_reg];
    assign out_free = !m_valid || m_ready;
    assign can_emit = !hold_vld_reg || out_free;
    assign q_pop    = flush_req;

    always_comb begin
        ph_next = ph_reg;  midx_next = midx_reg;  fidx_next = fidx_reg;
        val_next = val_reg;  frc_next = frc_reg;
        emit_req = 1'b0;  emit_byte = '0;  or_req = 1'b0;  or_bits = '0;
        flush_req = 1'b0;
        case (ph_reg)
            PH_HDR0: if (q_vld) begin
                emit_req  = 1'b1;
                emit_byte = cur_msg.hdr0;
                if (can_emit) begin
                    ph_next   = cur_msg.hdr1_vld ? PH_HDR1 : PH_FSTART;
                    fidx_next = '0;
                end
            end
            PH_HDR1: begin
                emit_req  = 1'b1;
                emit_byte = cur_msg.hdr1;
                if (can_emit) begin
                    ph_next   = PH_FSTART;
                    fidx_next = '0;
                end
            end
            PH_FSTART: begin
                if (!cur_fld.vld) begin
                    if (fidx_reg == 2'(NFLD - 1)) ph_next = PH_MEND;
                    else fidx_next = fidx_reg + 2'd1;
                end else begin
                    // low bits of the field share the previous byte
                    if (cur_fld.nprev != 3'd0) begin
                        or_req  = 1'b1;
                        or_bits = 8'(cur_fld.val << (4'd8 - {1'b0, cur_fld.nprev}));
                    end
                    val_next = cur_fld.val >> cur_fld.nprev;
                    frc_next = cur_fld.frc;
                    ph_next  = PH_FCHUNK;
                end
            end
            PH_FCHUNK: begin
                if (val_reg != '0 || frc_reg) begin
                    emit_req  = 1'b1;
                    emit_byte = {val_reg[5:0], 2'b00};
                    if (can_emit) begin
                        val_next = val_reg >> 6;
                        frc_next = 1'b0;
                    end
                end else begin
                    or_req  = 1'b1;
                    or_bits = 8'h01;      // end of field
                    if (fidx_reg == 2'(NFLD - 1)) ph_next = PH_MEND;
                    else begin
                        fidx_next = fidx_reg + 2'd1;
                        ph_next   = PH_FSTART;
                    end
                end
            end
            PH_MEND: begin
                or_req  = 1'b1;
                or_bits = 8'h03;          // end of message
                if (!midx_reg && q_desc.msg[1].vld) begin
                    midx_next = 1'b1;
                    ph_next   = PH_HDR0;
                end else begin
                    ph_next = PH_FLUSH;
                end
            end
            PH_FLUSH: if (out_free) begin
                flush_req = 1'b1;
                midx_next = 1'b0;
                ph_next   = PH_HDR0;
            end
            default: ph_next = PH_HDR0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_HDR0;  midx_reg <= 1'b0;  fidx_reg <= '0;
            hold_vld_reg <= 1'b0;  m_valid <= 1'b0;
        end else begin
            ph_reg   <= ph_next;  midx_reg <= midx_next;  fidx_reg <= fidx_next;
            val_reg  <= val_next;  frc_reg <= frc_next;
            if (flush_req || (emit_req && can_emit && hold_vld_reg)) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (emit_req && can_emit) begin
                if (hold_vld_reg) begin
                    m_data  <= hold_reg;
                    m_eom   <= (hold_reg[1:0] == 2'b11);
                    m_last  <= 1'b0;
                end
                hold_reg     <= emit_byte;
                hold_vld_reg <= 1'b1;
            end
            if (or_req) hold_reg <= hold_reg | or_bits;
            if (flush_req) begin
                m_data       <= hold_reg;
                m_eom        <= (hold_reg[1:0] == 2'b11);
                m_last       <= 1'b1;
                hold_vld_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/branch_trace_message_encoder_unit.sv =====
// Top level of the branch trace message encoder: front end, queue, byte serializer.
// Depends on btme_pkg, btme_front, btme_queue, btme_back.
//
//  channel   dir  payload                                         framing
//  s_axis    in   tdata: pc, is_32bit, is_branch, not_taken,       tuser: req_type
//                 is_indirect (zero pad to 40 bits)
//  m_axis    out  tdata: out_byte                                  tuser: end_of_message,
//                                                                  tlast: last byte of item
//  cfg       in   cfg_addr 0 trace_mode, 1 repeat_enables          write-only, no wait
//
// The front end takes one item per cycle while the two-entry descriptor queue has room.
// The serializer sets the drain rate: header bytes, then per used field slot a start step,
// a step per output byte and an end-mark step; one step per unused slot, one per message
// end and one to close the item. Items that emit no bytes never enter the queue.
// Output bytes sit in a one-byte hold stage so end marks can be merged before release.
// Reset (synchronous, active low) loads a pending sync message and empties the queue.
`default_nettype none
module branch_trace_message_encoder_unit import btme_pkg::*; #(
    parameter int ADDR_BITS  = DEF_ADDR_BITS,
    parameter int HIST_BITS  = DEF_HIST_BITS,
    parameter int ADDR_SKIP  = DEF_ADDR_SKIP,
    parameter int RCODE_BITS = DEF_RCODE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pc[31:0], is_32bit, is_branch, not_taken, is_indirect
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_byte
    output logic                  m_tuser,   // end_of_message
    output logic                  m_tlast
);

    logic  q_push, q_full, q_pop, q_vld;
    desc_t q_in, q_head;

    btme_front #(
        .ADDR_BITS(ADDR_BITS), .HIST_BITS(HIST_BITS),
        .ADDR_SKIP(ADDR_SKIP), .RCODE_BITS(RCODE_BITS)
    ) u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata), .in_user(s_tuser),
        .push(q_push), .push_desc(q_in), .q_full(q_full)
    );

    btme_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_desc(q_in), .full(q_full),
        .pop(q_pop), .head_vld(q_vld), .head_desc(q_head)
    );

    btme_back u_back (
        .aclk, .aresetn, .q_vld(q_vld), .q_desc(q_head), .q_pop(q_pop),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata),
        .m_eom(m_tuser), .m_last(m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/btme_checker.sv =====
// Port-level checks on the encoder output stream, bound to the top level.
// Depends on btme_pkg.
`default_nettype none
module btme_checker import btme_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_eom_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[1:0] == 2'b11)))
        else $error("end_of_message flag does not match end marks");

    a_last_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("item ended inside a message");

    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind branch_trace_message_encoder_unit btme_checker u_btme_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for branch_trace_message_encoder_unit.
// Drives retired-instruction and flush beats and predicts every trace message byte.
// Depends on btme_pkg and the design files.
`default_nettype none
module tb_top;
    import btme_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [7:0] SYNC_EVCODE = 8'h04;
    localparam logic [7:0] CORR_HIST   = 8'h40;

    typedef struct {
        logic [7:0] data;
        logic       eom;
        logic       last;
    } trace_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // pc[31:0], is_32bit, is_branch, not_taken, is_indirect
    logic                  s_tuser = 1'b0; // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // out_byte
    logic                  m_tuser;        // end_of_message
    logic                  m_tlast;

    branch_trace_message_encoder_unit dut (.*);

    always #2 aclk = ~aclk;

    // encoder model state
    logic [1:0]  trace_mode_q, repeat_en_q;
    logic [5:0]  pend_code;
    logic [31:0] icnt, hist, laddr, rcnt, pcnt, phist, plen, pword, pshift;
    logic [7:0]  msg_bytes[$];
    trace_byte_t exp_bytes[$];

    int  errors = 0, items_sent = 0, bytes_seen = 0, settings_run = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0, idle_cycles = 0;

    function automatic void or_last(logic [7:0] b);
        if (msg_bytes.size() > 0) msg_bytes[msg_bytes.size()-1] |= b;
    endfunction

    function automatic void add_field(logic [63:0] v, int np);
        if (np > 0) begin
            or_last(8'((v << (8 - np)) & 64'hFF));
            v = v >> np;
        end
        while (v != 0 || np < 0) begin
            msg_bytes.push_back({v[5:0], 2'b00});
            v = v >> 6;
            np = 0;
        end
        or_last(8'h01);
    endfunction

    function automatic logic [31:0] pattern_len(logic [31:0] p, logic [31:0] h);
        if (p[2:0] == p[30:28] && (p & 32'h0FFFFFF8) == ((h >> 3) & 32'h0FFFFFF8))
            return 28;
        if (p[0] == p[30] && (p & 32'h3FFFFFFE) == ((h >> 1) & 32'h3FFFFFFE))
            return 30;
        return 0;
    endfunction

    function automatic void encoder_reset();
        trace_mode_q = MODE_HIST_RP; repeat_en_q = 2'd3;
        pend_code = TC_SYNC; icnt = 0; hist = 1; laddr = 0;
        rcnt = 0; pcnt = 0; phist = 0; plen = 0; pword = 0; pshift = 0;
    endfunction

    function automatic void encode_item(logic flush, logic [31:0] addr, logic is4, logic br,
                                        logic nt, logic ind);
        logic [1:0]  mode;
        logic [5:0]  code;
        logic [31:0] sh, m, s2;
        bit          rep;
        mode = (trace_mode_q > MODE_HIST_RP) ? MODE_HIST_RP : trace_mode_q;
        msg_bytes.delete();
        if (flush && (icnt > 0 || plen != 0)) begin
            if (pend_code == TC_NONE) pend_code = TC_CORR;
            if (rcnt > 0) phist = 0;
        end
        if (pend_code != TC_NONE) begin
            code = pend_code;
            if (mode >= MODE_HIST_RP) begin
                rep = 1'b0;
                if (repeat_en_q[1] && code == TC_FULL) begin
                    sh = pshift & 3;
                    if (plen == 0) begin
                        plen = 31; pshift = 0; pword = hist; rcnt = 0; rep = 1'b1; hist = 1;
                    end else if ((hist >> sh) == pword) begin
                        hist = (32'd1 << sh) | (hist & ((32'd1 << sh) - 1));
                        rep = 1'b1;
                    end else if (rcnt == 1) begin
                        m = pattern_len(pword, hist);
                        if (m != 0) begin
                            plen = m;
                            pshift = 31 - m;
                            pword = pword >> pshift;
                            s2 = 2 * pshift;
                            hist = (32'd1 << s2) | (hist & ((32'd1 << s2) - 1));
                            rep = 1'b1;
                        end
                    end
                end else if (repeat_en_q[0] && code != TC_FULL && phist == hist &&
                             laddr == addr && pcnt == icnt) begin
                    rep = 1'b1; icnt = 0; hist = 1;
                end
                if (rep) begin
                    rcnt++;
                    code = TC_NONE;
                end else if (rcnt > 0 && plen != 0) begin
                    msg_bytes.push_back({TC_FULL, 2'b00});
                    msg_bytes.push_back(rcnt > 1 ? RCODE_MULTI : RCODE_ONE);
                    add_field(pword, 6 - DEF_RCODE_BITS);
                    if (rcnt > 1) add_field(rcnt, 0);
                    or_last(8'h03);
                    if (code == TC_FULL) begin
                        plen = 31; pshift = 0; pword = hist; rcnt = 1; code = TC_NONE;
                        hist = 1;
                    end else begin
                        rcnt = 0; plen = 0;
                    end
                end else if (rcnt > 0) begin
                    msg_bytes.push_back({TC_REPEAT, 2'b00});
                    add_field(rcnt, 0);
                    or_last(8'h03);
                    rcnt = 0;
                end
            end
            if (code == TC_INDHIST && hist == 1) code = TC_INDIRECT;
            if (rcnt == 0) phist = 0;
            if (code != TC_NONE) msg_bytes.push_back({code, 2'b00});
            case (code)
                TC_SYNC: begin
                    msg_bytes.push_back(SYNC_EVCODE);
                    add_field(icnt, 2);
                    icnt = 0;
                    add_field(addr >> DEF_ADDR_SKIP, 0);
                    laddr = addr;
                end
                TC_INDHIST, TC_INDIRECT: begin
                    phist = hist; pcnt = icnt;
                    msg_bytes.push_back(8'h00);
                    add_field(icnt, 4);
                    icnt = 0;
                    add_field((laddr ^ addr) >> DEF_ADDR_SKIP, -1);
                    laddr = addr;
                    if (code == TC_INDHIST) add_field(hist, 0);
                end
                TC_DIRECT: begin
                    add_field(icnt, -1);
                    icnt = 0;
                end
                TC_FULL: begin
                    phist = hist; pcnt = icnt;
                    msg_bytes.push_back(RCODE_ONE);
                    add_field(hist, 6 - DEF_RCODE_BITS);
                end
                TC_CORR: begin
                    msg_bytes.push_back(hist > 1 ? CORR_HIST : 8'h00);
                    add_field(icnt, -1);
                    icnt = 0;
                    if (hist > 1) add_field(hist, 0);
                end
                default: ;
            endcase
            if (msg_bytes.size() > 1) or_last(8'h03);
            else msg_bytes.delete();
            pend_code = TC_NONE;
            if (plen == 0) hist = 1;
        end
        icnt += (!flush && is4) ? 2 : 1;
        if (!flush) begin
            if (br) begin
                if (mode >= MODE_HIST) begin
                    hist = (hist << 1) | (nt ? 32'd0 : 32'd1);
                    if (hist[DEF_HIST_BITS]) pend_code = TC_FULL;
                end else if (!nt) begin
                    pend_code = TC_DIRECT;
                end
            end else if (ind) begin
                pend_code = (mode >= MODE_HIST) ? TC_INDHIST : TC_INDIRECT;
            end
        end
        foreach (msg_bytes[k])
            exp_bytes.push_back('{msg_bytes[k], msg_bytes[k][1:0] == 2'b11,
                                  k == msg_bytes.size() - 1});
    endfunction

    // one beat on the input side; returns after it is accepted
    task automatic send_item(logic flush, logic [31:0] pc, logic is4, logic br, logic nt,
                             logic ind);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ind, nt, br, is4, pc};
        s_tuser  <= flush;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_item(flush, pc, is4, br, nt, ind);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_TRACE_MODE) trace_mode_q = val;
        else repeat_en_q = val;
    endtask

    task automatic test_set_mode(logic [1:0] mode, logic [1:0] ren);
        wait_drained();
        write_cfg(CFG_TRACE_MODE, mode);
        write_cfg(CFG_REPEAT_EN, ren);
        settings_run++;
    endtask

    task automatic test_directed();
        send_item(0, 32'h0000_0000, 0, 0, 0, 0);   // carries the sync message
        send_item(1, 32'h0000_0000, 0, 0, 0, 0);   // flush with count pending
        send_item(1, 32'h0000_0002, 1, 1, 1, 1);   // flush right after flush, flags ignored
        send_item(0, 32'hFFFF_FFFE, 1, 1, 0, 0);
        send_item(0, 32'hFFFF_FFFF, 0, 1, 1, 0);
        send_item(0, 32'h8000_0000, 1, 0, 0, 1);   // indirect
        send_item(0, 32'h1234_5678, 0, 1, 0, 1);   // branch wins over indirect
        send_item(0, 32'h0000_0100, 1, 0, 0, 1);
        send_item(0, 32'h0000_0100, 0, 0, 0, 1);
        send_item(1, 32'hFFFF_FFFF, 1, 0, 0, 0);
        for (int i = 0; i < 10; i++)
            send_item(0, 32'h0000_2000 + 4 * i, i[0], 1, i[1], 0);
        send_item(1, 32'h0000_3000, 0, 0, 0, 0);   // correlation, with history when not in branch mode
    endtask

    // loop body repeated: same branch pattern and, with with_ind, the same indirect target each pass
    task automatic test_loops(int passes, bit with_ind);
        int          len;
        logic [31:0] base;
        logic [7:0]  outcome, wide;
        len = $urandom_range(1, 6);
        base = $urandom() & 32'hFFFF_FFFE;
        outcome = 8'($urandom());
        wide = 8'($urandom());
        for (int p = 0; p < passes; p++) begin
            for (int i = 0; i < len; i++)
                send_item(0, base + 4 * i, wide[i], 1, outcome[i], 0);
            if (with_ind) send_item(0, base + 4 * len, 0, 0, 0, 1);
        end
    endtask

    task automatic test_random(int n);
        logic [31:0] pc;
        for (int i = 0; i < n; i++) begin
            pc = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0000_4000 + 2 * $urandom_range(0, 31);
            send_item($urandom_range(0, 11) == 0, pc, 1'($urandom()), 1'($urandom()),
                      1'($urandom()), $urandom_range(0, 3) == 0);
        end
    endtask

    // result side: random stalls, then check against the oldest expected byte
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if (m_tvalid && m_tready) begin
            bytes_seen++;
            if (exp_bytes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: byte %h eom %b last %b",
                                           m_tdata, m_tuser, m_tlast);
            end else begin
                trace_byte_t e;
                e = exp_bytes.pop_front();
                if (m_tdata !== e.data || m_tuser !== e.eom || m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp byte %h eom %b last %b, got %h %b %b",
                                 e.data, e.eom, e.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && exp_bytes.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d bytes pending",
                     STALL_LIMIT, exp_bytes.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        encoder_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_set_mode(MODE_HIST_RP, 2'd3);
        test_loops(8, 1);
        test_loops(8, 0);
        test_random(20);
        test_set_mode(MODE_BRANCH, 2'd0);
        test_directed();
        test_loops(4, 1);
        test_random(20);
        test_set_mode(MODE_HIST, 2'd2);
        test_loops(6, 0);
        test_random(20);
        test_set_mode(2'd3, 2'd1);
        test_loops(8, 1);
        test_random(15);
        test_set_mode(MODE_HIST_RP, 2'd3);
        quiet = 1'b1;
        test_loops(6, 0);
        test_loops(6, 1);
        test_random(15);
        wait_drained();
        $display("covered %0d input beats over %0d register settings, %0d output bytes checked",
                 items_sent, settings_run, bytes_seen);
        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ===== branch_trace_message_encoder_unit.f =====
design/btme_pkg.sv
design/btme_front.sv
design/btme_queue.sv
design/btme_back.sv
design/branch_trace_message_encoder_unit.sv
design/btme_checker.sv
dv/tb_top.sv
